[hw/rtl/lru_frame_replacer_top_defines.svh]
// Assertion macros for the replacement list RTL.
`ifndef LRU_FRAME_REPLACER_TOP_DEFINES_SVH
`define LRU_FRAME_REPLACER_TOP_DEFINES_SVH

// Check a property at every clock edge outside reset.
`define LFR_ASSERT(name_, prop_, msg_) \
  name_: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop_)) else $error(msg_);

// Check that a condition in one cycle implies another in the next cycle.
`define LFR_ASSERT_NEXT(name_, ante_, cons_, msg_) \
  name_: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante_) |=> (cons_)) else $error(msg_);

`endif

[hw/rtl/lfr_pkg.sv]
// Types and constants of the replacement list.
`default_nettype none

package lfr_pkg;

  localparam int OpW    = 2;
  localparam int FrameW = 4;
  localparam int OccW   = 5;
  localparam int CapW   = 5;

  localparam logic [OpW-1:0] OpVictim = 2'd0;
  localparam logic [OpW-1:0] OpPin    = 2'd1;
  localparam logic [OpW-1:0] OpUnpin  = 2'd2;

  localparam logic [CapW-1:0] CapReset = 5'd16;

  typedef struct packed {
    logic [OpW-1:0]    opcode;
    logic [FrameW-1:0] frame_number;
  } req_t;

  typedef struct packed {
    logic              victim_found;
    logic [FrameW-1:0] victim_frame;
    logic [OccW-1:0]   occupancy;
  } res_t;

  // Command broadcast to every cell of the list.
  typedef struct packed {
    logic              victim;
    logic              remove;
    logic              append;
    logic [FrameW-1:0] frame;
  } cell_cmd_t;

  // Contents of one list slot as handed to the left neighbor.
  typedef struct packed {
    logic              valid;
    logic [FrameW-1:0] frame;
  } slot_t;

endpackage

`default_nettype wire

[hw/rtl/lfr_cell.sv]
// One slot of the replacement list: holds a frame and shifts toward the old end.
`default_nettype none

module lfr_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lfr_pkg::cell_cmd_t cmd_i,
  input  wire lfr_pkg::slot_t    right_i,
  input  wire logic              hit_i,
  input  wire logic              left_valid_i,
  output      lfr_pkg::slot_t    slot_o,
  output      logic              hit_o,
  output      logic              shifted_valid_o
);

  logic                      valid_q, valid_d;
  logic [lfr_pkg::FrameW-1:0] frame_q, frame_d;
  logic                      match;
  logic                      shift;
  logic                      pv;
  logic [lfr_pkg::FrameW-1:0] pf;
  logic                      load;

  assign match = valid_q && (frame_q == cmd_i.frame);
  assign hit_o = hit_i | match;

  // Close the gap left by a removal at or before this slot, or by taking a victim.
  assign shift = cmd_i.victim | (cmd_i.remove & (hit_i | match));
  assign pv    = shift ? right_i.valid : valid_q;
  assign pf    = shift ? right_i.frame : frame_q;

  // The first empty slot after the shift takes the appended frame.
  assign load  = cmd_i.append & ~pv & left_valid_i;

  assign valid_d = pv | load;
  assign frame_d = load ? cmd_i.frame : pf;

  assign shifted_valid_o = pv;
  assign slot_o.valid    = valid_q;
  assign slot_o.frame    = frame_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
  end

endmodule

`default_nettype wire

[hw/rtl/lru_frame_replacer_top.sv]
// Top level of the least-recently-unpinned frame replacement list.
// One word is taken on every clock edge with start high (busy stays low), and its
// result appears on res_o with result_valid_o high in the next cycle, for
// one cycle; the receiver cannot stall it, so it must take every result as it
// comes. The list is a chain of min(NUM_FRAMES, 16) cells that all shift toward
// the least-recent end together, which sets the one-item-per-cycle rate. Reset
// empties the list at once; no clearing pass. The capacity register is written
// via cfg_valid_i/cfg_data_i; the user must do so only while idle (not enforced).
`default_nettype none

`include "lru_frame_replacer_top_defines.svh"

module lru_frame_replacer_top #(
  parameter int NUM_FRAMES = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start,
  output      logic                     busy,
  input  wire lfr_pkg::req_t            req_i,
  output      logic                     result_valid_o,
  output      lfr_pkg::res_t            res_o,
  input  wire logic                     cfg_valid_i,
  output      logic                     cfg_ready_o,
  input  wire logic [lfr_pkg::CapW-1:0] cfg_data_i
);

  localparam int MaxFrames = 1 << lfr_pkg::FrameW;
  localparam int Depth     = (NUM_FRAMES < MaxFrames) ? NUM_FRAMES : MaxFrames;
  localparam int LenW      = $clog2(Depth + 1);

  logic [lfr_pkg::CapW-1:0] cap_q;
  logic [LenW-1:0]          len_q, len_d;
  logic                     res_valid_q;
  lfr_pkg::res_t            res_q, res_d;
  logic                     accept;
  logic                     in_range;
  logic                     victim_go;
  logic                     hit;
  lfr_pkg::cell_cmd_t       cmd;

  lfr_pkg::slot_t           slot_w  [Depth];
  lfr_pkg::slot_t           right_w [Depth];
  logic                     hit_w   [Depth+1];
  logic                     pv_w    [Depth+1];
  logic [Depth-1:0]         valid_vec;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start & ~busy;
  assign in_range    = int'(req_i.frame_number) < NUM_FRAMES;
  assign victim_go   = accept && (req_i.opcode == lfr_pkg::OpVictim) &&
                       (cap_q != '0) && slot_w[0].valid;

  always_comb begin
    cmd        = '0;
    cmd.frame  = req_i.frame_number;
    if (accept) begin
      unique case (req_i.opcode)
        lfr_pkg::OpVictim: cmd.victim = victim_go;
        lfr_pkg::OpPin:    cmd.remove = in_range;
        lfr_pkg::OpUnpin: begin
          cmd.remove = in_range;
          cmd.append = in_range;
        end
        default: ;
      endcase
    end
  end

  assign hit_w[0] = 1'b0;
  assign pv_w[0]  = 1'b1;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    if (i == Depth - 1) begin : g_last
      assign right_w[i] = '0;
    end else begin : g_mid
      assign right_w[i] = slot_w[i+1];
    end

    lfr_cell u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .cmd_i          (cmd),
      .right_i        (right_w[i]),
      .hit_i          (hit_w[i]),
      .left_valid_i   (pv_w[i]),
      .slot_o         (slot_w[i]),
      .hit_o          (hit_w[i+1]),
      .shifted_valid_o(pv_w[i+1])
    );

    assign valid_vec[i] = slot_w[i].valid;
  end

  assign hit = hit_w[Depth];

  // Track occupancy alongside the chain.
  always_comb begin
    len_d = len_q;
    if (victim_go || (cmd.remove && hit && !cmd.append)) begin
      len_d = len_q - LenW'(1);
    end else if (cmd.append && !hit) begin
      len_d = len_q + LenW'(1);
    end
  end

  always_comb begin
    res_d              = '0;
    res_d.victim_found = victim_go;
    res_d.victim_frame = victim_go ? slot_w[0].frame : '0;
    res_d.occupancy    = lfr_pkg::OccW'(len_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= lfr_pkg::CapReset;
      len_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
      if (accept) begin
        len_q <= len_d;
      end
      res_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign result_valid_o = res_valid_q;
  assign res_o          = res_q;

  `LFR_ASSERT(a_len_matches, $countones(valid_vec) == int'(len_q), "occupancy count drifted")
  `LFR_ASSERT(a_list_packed, ((valid_vec + Depth'(1)) & valid_vec) == '0, "list has a hole")
  `LFR_ASSERT_NEXT(a_result_follows, start && !busy, result_valid_o, "result word missing")
  `LFR_ASSERT(a_no_victim_zero, !(result_valid_o && !res_o.victim_found) || (res_o.victim_frame == '0), "victim frame set without victim")

endmodule

`default_nettype wire

[tb/lfr_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the replacement list: tracks the list, predicts each result, compares.
module lfr_checker #(
  parameter int NUM_FRAMES = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic                     busy_i,
  input  lfr_pkg::req_t            req_i,
  input  logic                     res_valid_i,
  input  lfr_pkg::res_t            res_i,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [lfr_pkg::CapW-1:0] cfg_data_i,
  output int                       fail_count_o,
  output int                       pending_o
);
  import lfr_pkg::*;

  // Shadow list: slot 0 holds the least recently unpinned frame.
  logic [FrameW-1:0] lru_order [NUM_FRAMES];
  logic              in_list   [NUM_FRAMES];
  int unsigned       list_len;
  logic [CapW-1:0]   capacity_q;

  res_t result_q [$];
  res_t want;
  int   mismatches;

  assign fail_count_o = mismatches;

  // Close the gap left by the slot at pos.
  function automatic void close_slot(int unsigned pos);
    for (int unsigned i = pos; i + 1 < list_len; i++) begin
      lru_order[i] = lru_order[i + 1];
    end
    if (list_len > 0) list_len--;
  endfunction

  function automatic void take_out(logic [FrameW-1:0] frame);
    for (int unsigned i = 0; i < list_len; i++) begin
      if (lru_order[i] == frame) begin
        close_slot(i);
        break;
      end
    end
    in_list[frame] = 1'b0;
  endfunction

  function automatic res_t list_result(req_t cmd);
    res_t              r;
    logic [FrameW-1:0] f;
    r = '0;
    f = cmd.frame_number;
    case (cmd.opcode)
      OpVictim: begin
        if (capacity_q != '0 && list_len > 0) begin
          r.victim_found = 1'b1;
          r.victim_frame = lru_order[0];
          close_slot(0);
          if (int'(r.victim_frame) < NUM_FRAMES) in_list[r.victim_frame] = 1'b0;
        end
      end
      OpPin: begin
        if (int'(f) < NUM_FRAMES && in_list[f]) take_out(f);
      end
      OpUnpin: begin
        // Refresh a present frame or add a new one: drop it if present, then append at the recent end.
        if (int'(f) < NUM_FRAMES) begin
          if (in_list[f]) take_out(f);
          if (list_len < NUM_FRAMES) begin
            lru_order[list_len] = f;
            list_len++;
            in_list[f] = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.occupancy = list_len[OccW-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_FRAMES; i++) begin
        lru_order[i] = '0;
        in_list[i]   = 1'b0;
      end
      list_len   = 0;
      capacity_q = CapReset;
      mismatches = 0;
      result_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) capacity_q = cfg_data_i;
      if (start_i && !busy_i) result_q.push_back(list_result(req_i));
      if (res_valid_i) begin
        if (result_q.size() == 0) begin
          $error("result word with nothing expected: found %0d frame %0d occupancy %0d",
                 res_i.victim_found, res_i.victim_frame, res_i.occupancy);
          mismatches++;
        end else begin
          want = result_q.pop_front();
          if (res_i.victim_found !== want.victim_found) begin
            $error("victim_found: expected %0d, got %0d", want.victim_found,
                   res_i.victim_found);
            mismatches++;
          end
          if (res_i.victim_frame !== want.victim_frame) begin
            $error("victim_frame: expected %0d, got %0d", want.victim_frame,
                   res_i.victim_frame);
            mismatches++;
          end
          if (res_i.occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, res_i.occupancy);
            mismatches++;
          end
        end
      end
      pending_o <= result_q.size();
    end
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Top of the replacement list regression: clock, reset, stimulus and verdict.
module tb;
  import lfr_pkg::*;

  localparam int NumFrames = 16;
  localparam logic [OpW-1:0] OpUnused = 2'd3;
  localparam int NumPhases = 6;
  localparam int PhaseItems = 250;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            start       = 1'b0;
  req_t            req_i       = '0;
  logic            cfg_valid_i = 1'b0;
  logic [CapW-1:0] cfg_data_i  = '0;
  logic            busy;
  logic            result_valid_o;
  res_t            res_o;
  logic            cfg_ready_o;
  int              fail_count;
  int              pending;
  int              idle_pct = 0;

  always #5 clk_i = ~clk_i;

  lru_frame_replacer_top #(
    .NUM_FRAMES(NumFrames)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_i         (req_i),
    .result_valid_o(result_valid_o),
    .res_o         (res_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  lfr_checker #(
    .NUM_FRAMES(NumFrames)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .req_i       (req_i),
    .res_valid_i (result_valid_o),
    .res_i       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  function automatic req_t mk_cmd(logic [OpW-1:0] op, int frame);
    req_t c;
    c.opcode       = op;
    c.frame_number = frame[FrameW-1:0];
    return c;
  endfunction

  function automatic req_t random_cmd(int unpin_w, int pin_w, int victim_w, int pool);
    int roll;
    roll = $urandom_range(99);
    if (roll < unpin_w) return mk_cmd(OpUnpin, $urandom_range(pool - 1));
    if (roll < unpin_w + pin_w) return mk_cmd(OpPin, $urandom_range(pool - 1));
    if (roll < unpin_w + pin_w + victim_w) return mk_cmd(OpVictim, $urandom_range(15));
    return mk_cmd(OpUnused, $urandom_range(15));
  endfunction

  // Drop start for a random gap and put junk on the request bus meanwhile.
  task automatic idle_gap();
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      req_i <= mk_cmd(OpW'($urandom_range(3)), $urandom_range(15));
      @(posedge clk_i);
    end
  endtask

  task automatic issue(req_t cmd);
    idle_gap();
    start <= 1'b1;
    req_i <= cmd;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Drain the list results, then write the capacity word.
  task automatic set_capacity(logic [CapW-1:0] value);
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    #2_000_000;
    $display("lru_frame_replacer_top regression: fail");
    $finish;
  end

  initial begin
    int caps   [NumPhases] = '{16, 31, 1, 0, 17, 16};
    int idles  [NumPhases] = '{0, 58, 38, 0, 58, 38};
    int unpins [NumPhases] = '{50, 45, 40, 60, 45, 40};
    int pins   [NumPhases] = '{15, 20, 25, 10, 20, 15};
    int victims[NumPhases] = '{30, 30, 30, 25, 30, 40};
    int pool;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty list, absent pin, unused opcode, refresh, double pin, drain.
    issue(mk_cmd(OpVictim, 0));
    issue(mk_cmd(OpPin, 5));
    issue(mk_cmd(OpUnused, 9));
    issue(mk_cmd(OpUnpin, 0));
    issue(mk_cmd(OpUnpin, 15));
    issue(mk_cmd(OpUnpin, 7));
    issue(mk_cmd(OpUnpin, 0));
    issue(mk_cmd(OpVictim, 0));
    issue(mk_cmd(OpPin, 7));
    issue(mk_cmd(OpPin, 7));
    issue(mk_cmd(OpVictim, 15));
    issue(mk_cmd(OpVictim, 0));
    issue(mk_cmd(OpUnused, 15));

    // Zero capacity blocks victims on a non-empty list.
    set_capacity(5'd0);
    issue(mk_cmd(OpUnpin, 3));
    issue(mk_cmd(OpUnpin, 12));
    issue(mk_cmd(OpVictim, 0));
    issue(mk_cmd(OpPin, 3));
    issue(mk_cmd(OpVictim, 0));
    set_capacity(5'd31);
    issue(mk_cmd(OpVictim, 0));
    issue(mk_cmd(OpVictim, 0));

    for (int p = 0; p < NumPhases; p++) begin
      set_capacity(caps[p][CapW-1:0]);
      idle_pct = idles[p];
      pool = NumFrames;
      for (int i = 0; i < PhaseItems; i++) begin
        // Every 50 items, pick at random a narrow frame pool (many hits) or the full range.
        if (i % 50 == 0) pool = ($urandom_range(1) == 0) ? 4 : NumFrames;
        issue(random_cmd(unpins[p], pins[p], victims[p], pool));
      end
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("lru_frame_replacer_top regression: pass");
    end else begin
      $display("lru_frame_replacer_top regression: fail");
    end
    $finish;
  end

endmodule
